// ===== rtl/ordered_value_list_macros.svh =====
// Assertion macros for the ordered value list.
// Taken in by the top level; depends on nothing else.
`ifndef ORDERED_VALUE_LIST_MACROS_SVH
`define ORDERED_VALUE_LIST_MACROS_SVH

// Same-cycle implication, muted during reset.
`define OVL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted during reset.
`define OVL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ovl_pkg.sv =====
// Shared types and constants for the ordered value list.
// Used by ovl_front, ovl_cmd_queue, ovl_back and ordered_value_list.
package ovl_pkg;

   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // request action codes
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LIST   = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   // command queue between front and back (depth is a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] entry_value;
      logic [COUNT_W-1:0]        entry_count;
      logic                      last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_REMOVE,
      OP_LIST,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SEARCH_RD,
      BK_SEARCH_CMP,
      BK_SHIFT,
      BK_SHIFT_WR,
      BK_LIST_RD,
      BK_LIST_EMIT
   } back_state_type;

endpackage

// ===== rtl/ovl_front.sv =====
// Front stage: registers each request and decodes its action into a command.
// Depends on ovl_pkg.
module ovl_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ovl_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output ovl_pkg::cmd_type cmd_data
);

   logic             fr_valid_ff;
   logic             fr_valid_in;
   ovl_pkg::cmd_type fr_cmd_ff;
   ovl_pkg::cmd_type fr_cmd_in;

   assign req_ready = !fr_valid_ff || cmd_ready;
   assign cmd_valid = fr_valid_ff;
   assign cmd_data  = fr_cmd_ff;

   always_comb begin
      fr_cmd_in.value = req_data.value;
      case (req_data.action)
         ovl_pkg::ACT_APPEND: begin
            fr_cmd_in.op = ovl_pkg::OP_APPEND;
         end
         ovl_pkg::ACT_REMOVE: begin
            fr_cmd_in.op = ovl_pkg::OP_REMOVE;
         end
         ovl_pkg::ACT_LIST: begin
            fr_cmd_in.op = ovl_pkg::OP_LIST;
         end
         default: begin
            fr_cmd_in.op = ovl_pkg::OP_NOP;
         end
      endcase
   end

   always_comb begin
      fr_valid_in = fr_valid_ff;
      if (req_ready) begin
         fr_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         fr_cmd_ff <= fr_cmd_in;
      end
   end

endmodule

// ===== rtl/ovl_cmd_queue.sv =====
// Short command queue between the front stage and the back sequencer.
// Depends on ovl_pkg.
module ovl_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ovl_pkg::cmd_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output ovl_pkg::cmd_type out_data
);

   ovl_pkg::cmd_type                 q_mem_ff [ovl_pkg::QUEUE_DEPTH];
   logic [ovl_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [ovl_pkg::QPTR_W-1:0]       wr_ptr_in;
   logic [ovl_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [ovl_pkg::QPTR_W-1:0]       rd_ptr_in;
   logic [ovl_pkg::QCNT_W-1:0]       cnt_ff;
   logic [ovl_pkg::QCNT_W-1:0]       cnt_in;
   logic                             push;
   logic                             pop;

   localparam logic [ovl_pkg::QCNT_W-1:0] QFULL = ovl_pkg::QCNT_W'(ovl_pkg::QUEUE_DEPTH);

   assign in_ready  = (cnt_ff != QFULL);
   assign out_valid = (cnt_ff != '0);
   assign out_data  = q_mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/ovl_back.sv =====
// Back sequencer: entry memory, occupancy, search/shift/list walk, response register.
// Depends on ovl_pkg.
module ovl_back #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ovl_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ovl_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   ovl_pkg::back_state_type state_ff;
   ovl_pkg::back_state_type state_in;

   logic [ovl_pkg::VALUE_W-1:0] entry_mem_ff [CAPACITY];
   logic [ovl_pkg::VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]            rd_addr;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [ovl_pkg::VALUE_W-1:0] wr_data;

   logic [CNT_W-1:0]            occ_ff;
   logic [CNT_W-1:0]            occ_in;
   logic [CNT_W-1:0]            idx_ff;
   logic [CNT_W-1:0]            idx_in;
   logic [CNT_W-1:0]            idx_nx;
   logic [ovl_pkg::VALUE_W-1:0] key_ff;
   logic [ovl_pkg::VALUE_W-1:0] key_in;

   logic                        list_full;
   logic                        list_empty;
   logic                        more;
   logic                        match;
   logic                        out_free;
   logic                        cmd_fire;

   logic                          emit;
   logic                          emit_fire;
   logic [ovl_pkg::STATUS_W-1:0]  res_status;
   logic [ovl_pkg::VALUE_W-1:0]   res_value;
   logic [CNT_W-1:0]              res_cnt;
   logic                          res_last;
   logic [CNT_W+ovl_pkg::COUNT_W-1:0] cnt_ext;
   ovl_pkg::rsp_type              emit_res;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   ovl_pkg::rsp_type rsp_data_ff;

   assign list_full  = (occ_ff == CAP_CNT);
   assign list_empty = (occ_ff == '0);
   assign idx_nx     = idx_ff + 1'b1;
   assign more       = (idx_nx < occ_ff);
   assign match      = (rd_data_ff == key_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cmd_fire   = cmd_valid && cmd_ready;
   assign emit_fire  = emit && out_free;

   // next state and walk counters
   always_comb begin
      state_in = state_ff;
      occ_in   = occ_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      case (state_ff)
         ovl_pkg::BK_IDLE: begin
            if (cmd_fire) begin
               case (cmd_data.op)
                  ovl_pkg::OP_APPEND: begin
                     if (!list_full) begin
                        occ_in = occ_ff + 1'b1;
                     end
                  end
                  ovl_pkg::OP_REMOVE: begin
                     if (!list_empty) begin
                        key_in   = cmd_data.value;
                        idx_in   = '0;
                        state_in = ovl_pkg::BK_SEARCH_RD;
                     end
                  end
                  ovl_pkg::OP_LIST: begin
                     if (!list_empty) begin
                        idx_in   = '0;
                        state_in = ovl_pkg::BK_LIST_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ovl_pkg::BK_SEARCH_RD: begin
            state_in = ovl_pkg::BK_SEARCH_CMP;
         end
         ovl_pkg::BK_SEARCH_CMP: begin
            if (match) begin
               state_in = ovl_pkg::BK_SHIFT;
            end else if (more) begin
               idx_in   = idx_nx;
               state_in = ovl_pkg::BK_SEARCH_RD;
            end else if (out_free) begin
               state_in = ovl_pkg::BK_IDLE;
            end
         end
         ovl_pkg::BK_SHIFT: begin
            if (more) begin
               state_in = ovl_pkg::BK_SHIFT_WR;
            end else if (out_free) begin
               occ_in   = occ_ff - 1'b1;
               state_in = ovl_pkg::BK_IDLE;
            end
         end
         ovl_pkg::BK_SHIFT_WR: begin
            idx_in   = idx_nx;
            state_in = ovl_pkg::BK_SHIFT;
         end
         ovl_pkg::BK_LIST_RD: begin
            state_in = ovl_pkg::BK_LIST_EMIT;
         end
         ovl_pkg::BK_LIST_EMIT: begin
            if (out_free) begin
               if (more) begin
                  idx_in   = idx_nx;
                  state_in = ovl_pkg::BK_LIST_RD;
               end else begin
                  state_in = ovl_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = ovl_pkg::BK_IDLE;
         end
      endcase
   end

   // memory port controls and response to emit
   always_comb begin
      cmd_ready  = 1'b0;
      emit       = 1'b0;
      res_status = ovl_pkg::ST_OK;
      res_value  = '0;
      res_cnt    = occ_ff;
      res_last   = 1'b1;
      rd_addr    = idx_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = idx_ff[IDX_W-1:0];
      wr_data    = rd_data_ff;
      case (state_ff)
         ovl_pkg::BK_IDLE: begin
            cmd_ready = out_free;
            if (cmd_valid) begin
               emit = 1'b1;
               case (cmd_data.op)
                  ovl_pkg::OP_APPEND: begin
                     if (list_full) begin
                        res_status = ovl_pkg::ST_FULL;
                     end else begin
                        res_cnt = occ_ff + 1'b1;
                        wr_en   = out_free;
                        wr_addr = occ_ff[IDX_W-1:0];
                        wr_data = cmd_data.value;
                     end
                  end
                  ovl_pkg::OP_REMOVE: begin
                     emit       = list_empty;
                     res_status = ovl_pkg::ST_NOT_FOUND;
                  end
                  ovl_pkg::OP_LIST: begin
                     emit       = list_empty;
                     res_status = ovl_pkg::ST_EMPTY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ovl_pkg::BK_SEARCH_CMP: begin
            if (!match && !more) begin
               emit       = 1'b1;
               res_status = ovl_pkg::ST_NOT_FOUND;
            end
         end
         ovl_pkg::BK_SHIFT: begin
            rd_addr = idx_nx[IDX_W-1:0];
            if (!more) begin
               emit    = 1'b1;
               res_cnt = occ_ff - 1'b1;
            end
         end
         ovl_pkg::BK_SHIFT_WR: begin
            // move the later entry one place toward the head
            rd_addr = idx_nx[IDX_W-1:0];
            wr_en   = 1'b1;
         end
         ovl_pkg::BK_LIST_EMIT: begin
            emit      = 1'b1;
            res_value = rd_data_ff;
            res_last  = !more;
         end
         default: begin
         end
      endcase
   end

   assign cnt_ext  = {{ovl_pkg::COUNT_W{1'b0}}, res_cnt};
   assign emit_res = '{status:      res_status,
                       entry_value: res_value,
                       entry_count: cnt_ext[ovl_pkg::COUNT_W-1:0],
                       last:        res_last};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ovl_pkg::BK_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      key_ff <= key_in;
      if (emit_fire) begin
         rsp_data_ff <= emit_res;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/ordered_value_list.sv =====
// Ordered value list top level: front decode, command queue, back sequencer.
// Depends on ovl_pkg, ovl_front, ovl_cmd_queue, ovl_back and the macro header.
//
//   channel   ports                          direction
//   request   req_valid req_ready req_data   in  (action, value)
//   response  rsp_valid rsp_ready rsp_data   out (status, entry_value, entry_count, last)
//
// A request is held in the front register and then waits in a two-entry queue.
// Append, unknown actions and remove/list on an empty list are answered from the idle state.
// Remove reads and compares each entry searched (SEARCH_RD, SEARCH_CMP), then moves each
// later entry up (SHIFT, SHIFT_WR) and responds from SHIFT once a match is found; a list
// reads and emits each entry (LIST_RD, LIST_EMIT): the entry memory has a single registered read port.
// Reset clears occupancy, the back state, the valid flags and the queue pointers; no clearing pass runs.
// A stalled response holds the back sequencer while the front keeps taking requests until the queue fills.
`include "ordered_value_list_macros.svh"

module ordered_value_list #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ovl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ovl_pkg::rsp_type rsp_data
);

   logic             fr_valid;
   logic             fr_ready;
   ovl_pkg::cmd_type fr_cmd;
   logic             bk_valid;
   logic             bk_ready;
   ovl_pkg::cmd_type bk_cmd;

   ovl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (fr_valid),
      .cmd_ready (fr_ready),
      .cmd_data  (fr_cmd)
   );

   ovl_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_cmd),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (bk_cmd)
   );

   ovl_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (bk_valid),
      .cmd_ready (bk_ready),
      .cmd_data  (bk_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `OVL_ASSERT_NEXT(a_front_loads, clock, reset, req_valid && req_ready, fr_valid, "accepted request missing from front stage")
   `OVL_ASSERT_IMPLY(a_back_takes_with_room, clock, reset, bk_valid && bk_ready, !rsp_valid || rsp_ready, "command taken while response register blocked")
   `OVL_ASSERT_IMPLY(a_empty_rsp, clock, reset, rsp_valid && rsp_data.status == ovl_pkg::ST_EMPTY, rsp_data.entry_count == '0 && rsp_data.last, "empty response with nonzero count or no last")

endmodule
